// File: rtl/pdf_content_text_extractor_assert.svh
// Assertion macros for the PDF content-stream text extractor.
// Expects signals named clk and rst_n in the module that includes this file.
`ifndef PDF_CONTENT_TEXT_EXTRACTOR_ASSERT_SVH
`define PDF_CONTENT_TEXT_EXTRACTOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PTE_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pdf text extractor: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define PTE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pdf text extractor: next-cycle check failed");

`endif

// File: rtl/pdfte_pkg.sv
// Shared types, constants and helper functions of the PDF text extractor.
// No dependencies; the other RTL modules refer to it by scoped names.
`default_nettype none

package pdfte_pkg;

  // History window geometry.
  localparam int HIST_DEPTH = 15;
  localparam int HIST_CNT_W = $clog2(HIST_DEPTH);
  // The number before a TD token ends five slots from the end of the window.
  localparam int TD_LAST    = HIST_DEPTH - 5;
  localparam int SCAN_STEPS = HIST_DEPTH - 1;
  localparam int SNAP_AT    = TD_LAST - 1;

  // Result queue holds every result of one byte.
  localparam int Q_DEPTH = 3;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam int IP_W  = 32;
  localparam int CNT_W = 32;
  localparam int THR_W = 16;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = CFG_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_TAB_GAP   = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_SPACE_GAP = 1'b1;
  localparam logic [THR_W-1:0] TAB_GAP_RESET   = 16'd1000;
  localparam logic [THR_W-1:0] SPACE_GAP_RESET = 16'd100;

  // Character codes.
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_TILDE = 8'h7e;
  localparam logic [7:0] CH_HIGH  = 8'h80;
  localparam logic [7:0] CH_FF    = 8'hff;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_CLEAR
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WORK
  } state_t;

  typedef struct packed {
    logic            any;
    logic [IP_W-1:0] ip;
    logic            frac_nz;
  } num_t;

  typedef struct packed {
    logic             start;
    logic             step;
    logic             snap;
  } scan_ctl_t;

  typedef struct packed {
    logic [7:0]       text_byte;
    logic             last;
    logic [CNT_W-1:0] count;
  } entry_t;

  function automatic logic is_gap(input logic [7:0] ch);
    return (ch == CH_SPACE) || (ch == CH_CR) || (ch == CH_LF);
  endfunction

  function automatic logic is_digit(input logic [7:0] ch);
    return (ch >= CH_ZERO) && (ch <= CH_NINE);
  endfunction

  function automatic logic is_print(input logic [7:0] ch);
    return ((ch >= CH_SPACE) && (ch <= CH_TILDE)) || ((ch >= CH_HIGH) && (ch != CH_FF));
  endfunction

endpackage

`default_nettype wire

// File: rtl/pdfte_cell.sv
// One byte cell of the history chain: holds, takes its neighbor's byte, or clears.
// Depends on pdfte_pkg.
`default_nettype none

module pdfte_cell (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire pdfte_pkg::cell_op_t op,
  input  wire logic [7:0]          nbr,
  output logic [7:0]               q
);

  logic [7:0] q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= pdfte_pkg::CH_SPACE;
    end else begin
      unique case (op)
        pdfte_pkg::CELL_HOLD:  q_r <= q_r;
        pdfte_pkg::CELL_LOAD:  q_r <= nbr;
        pdfte_pkg::CELL_CLEAR: q_r <= pdfte_pkg::CH_SPACE;
        default:               q_r <= q_r;
      endcase
    end
  end

  assign q = q_r;

endmodule

`default_nettype wire

// File: rtl/pdfte_numscan.sv
// Number scanner: parses the history window one byte per cycle while ctl.step is set, left to right.
// Depends on pdfte_pkg.
`default_nettype none

module pdfte_numscan (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire pdfte_pkg::scan_ctl_t ctl,
  input  wire logic [7:0]           ch,
  output pdfte_pkg::num_t           num_a,
  output pdfte_pkg::num_t           num_b
);

  typedef struct packed {
    logic                       active;
    logic                       stopped;
    logic                       in_frac;
    logic                       any;
    logic                       frac_nz;
    logic [pdfte_pkg::IP_W-1:0] ip;
  } scan_t;

  // A digit or dot continues the current run or starts a fresh one. A space
  // closes the run but keeps its value, so the run just before trailing
  // spaces survives; any other byte discards it.
  function automatic scan_t scan_char(input scan_t s, input logic [7:0] c);
    scan_t                        r;
    logic [pdfte_pkg::IP_W+3:0]   wide;
    r    = s;
    wide = '0;
    if (pdfte_pkg::is_digit(c) || (c == pdfte_pkg::CH_DOT)) begin
      if (!s.active) begin
        r = '0;
      end
      r.active = 1'b1;
      if (!r.stopped) begin
        if (pdfte_pkg::is_digit(c)) begin
          r.any = 1'b1;
          if (r.in_frac) begin
            r.frac_nz = r.frac_nz | (c != pdfte_pkg::CH_ZERO);
          end else begin
            wide = ({4'd0, r.ip} << 3) + ({4'd0, r.ip} << 1)
                 + {{pdfte_pkg::IP_W{1'b0}}, c[3:0]};
            r.ip = (|wide[pdfte_pkg::IP_W+3:pdfte_pkg::IP_W]) ? '1
                 : wide[pdfte_pkg::IP_W-1:0];
          end
        end else if (r.in_frac) begin
          r.stopped = 1'b1;
        end else begin
          r.in_frac = 1'b1;
        end
      end
    end else if (c == pdfte_pkg::CH_SPACE) begin
      r.active = 1'b0;
    end else begin
      r = '0;
    end
    return r;
  endfunction

  scan_t           st_r;
  scan_t           st_nxt;
  pdfte_pkg::num_t snap_r;

  assign st_nxt = scan_char(st_r, ch);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (ctl.start) begin
      st_r <= '0;
    end else if (ctl.step) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step && ctl.snap) begin
      snap_r <= '{any: st_nxt.any, ip: st_nxt.ip, frac_nz: st_nxt.frac_nz};
    end
  end

  assign num_a = snap_r;
  assign num_b = '{any: st_r.any, ip: st_r.ip, frac_nz: st_r.frac_nz};

endmodule

`default_nettype wire

// File: rtl/pdfte_outq.sv
// Result queue: loads all results of one byte at once and hands them out in order.
// Depends on pdfte_pkg.
`default_nettype none

module pdfte_outq (
  input  wire logic                                          clk,
  input  wire logic                                          rst_n,
  input  wire logic                                          push,
  input  wire logic [pdfte_pkg::Q_CNT_W-1:0]                 push_n,
  input  wire pdfte_pkg::entry_t [pdfte_pkg::Q_DEPTH-1:0]    push_ent,
  input  wire logic                                          out_ready,
  output logic                                               out_valid,
  output pdfte_pkg::entry_t                                  head,
  output logic                                               empty
);

  pdfte_pkg::entry_t                 slot_r [pdfte_pkg::Q_DEPTH];
  logic [pdfte_pkg::Q_CNT_W-1:0]     cnt_r;
  logic                              pop;

  assign out_valid = (cnt_r != '0);
  assign empty     = (cnt_r == '0);
  assign pop       = out_valid && out_ready;
  assign head      = slot_r[0];

  // A push only happens into an empty queue, so it never meets a pop.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (push) begin
      cnt_r <= push_n;
    end else if (pop) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      for (int i = 0; i < pdfte_pkg::Q_DEPTH; i++) begin
        slot_r[i] <= push_ent[i];
      end
    end else if (pop) begin
      for (int i = 0; i < pdfte_pkg::Q_DEPTH - 1; i++) begin
        slot_r[i] <= slot_r[i + 1];
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/pdf_content_text_extractor.sv
// PDF content-stream text extractor, top level; uses pdfte_pkg, pdfte_cell,
// pdfte_numscan, pdfte_outq. Most bytes go from IDLE (accept) to WORK (results into the queue).
// A TD token in a text object or an opening parenthesis needs the number before it: the
// 15-cell history ring rotates once through the scanner in SCAN, between accept and WORK.
// Results leave one per cycle while out_ready is high, from a 3-entry queue.
// rst_n (synchronous, active low) fills the window with spaces, clears flags and count, gaps 1000/100.
`default_nettype none

`include "pdf_content_text_extractor_assert.svh"

module pdf_content_text_extractor (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [7:0]                          in_byte,
  input  wire logic                                in_end_of_stream,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [7:0]                               out_text_byte,
  output logic                                     out_last_of_run,
  output logic [31:0]                              out_emitted_count,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [pdfte_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire logic [pdfte_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [pdfte_pkg::CFG_DATA_W-1:0]         prdata,
  output logic                                     pready
);

  localparam int D = pdfte_pkg::HIST_DEPTH;

  // Configuration registers.
  logic [pdfte_pkg::THR_W-1:0] tab_thr_r;
  logic [pdfte_pkg::THR_W-1:0] space_thr_r;
  logic                        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tab_thr_r   <= pdfte_pkg::TAB_GAP_RESET;
      space_thr_r <= pdfte_pkg::SPACE_GAP_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[pdfte_pkg::CFG_ADDR_W-1:2])
        pdfte_pkg::REG_TAB_GAP:   tab_thr_r   <= pwdata[pdfte_pkg::THR_W-1:0];
        pdfte_pkg::REG_SPACE_GAP: space_thr_r <= pwdata[pdfte_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[pdfte_pkg::CFG_ADDR_W-1:2])
      pdfte_pkg::REG_TAB_GAP:
        prdata = {{(pdfte_pkg::CFG_DATA_W-pdfte_pkg::THR_W){1'b0}}, tab_thr_r};
      pdfte_pkg::REG_SPACE_GAP:
        prdata = {{(pdfte_pkg::CFG_DATA_W-pdfte_pkg::THR_W){1'b0}}, space_thr_r};
      default:
        prdata = '0;
    endcase
  end

  // Control state.
  pdfte_pkg::state_t              state_r;
  pdfte_pkg::state_t              state_nxt;
  logic [pdfte_pkg::HIST_CNT_W-1:0] scan_cnt_r;
  logic                           in_text_r, in_string_r, esc_r;
  logic                           in_text_nxt, in_string_nxt, esc_nxt;
  logic [pdfte_pkg::CNT_W-1:0]    counter_r;
  logic [pdfte_pkg::CNT_W-1:0]    counter_nxt;

  // Per-byte plan, taken at accept.
  logic [7:0] c_r;
  logic       eos_r, td_r, et_r, open_r, strc_r;

  // History chain.
  logic [7:0]           hist     [D];
  logic [7:0]           cell_nbr [D];
  pdfte_pkg::cell_op_t  cell_op;
  logic                 rot_sel;

  for (genvar i = 0; i < D; i++) begin : g_chain
    if (i < D - 1) begin : g_mid
      assign cell_nbr[i] = hist[i + 1];
    end else begin : g_end
      // The ring closes during a scan; otherwise the new byte enters here.
      assign cell_nbr[i] = rot_sel ? hist[0] : c_r;
    end
    pdfte_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .op   (cell_op),
      .nbr  (cell_nbr[i]),
      .q    (hist[i])
    );
  end

  // Number scanner.
  pdfte_pkg::scan_ctl_t scan_ctl;
  pdfte_pkg::num_t      num_a;
  pdfte_pkg::num_t      num_b;

  pdfte_numscan u_numscan (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (scan_ctl),
    .ch   (hist[1]),
    .num_a(num_a),
    .num_b(num_b)
  );

  // Decisions on the incoming byte, from the window before it shifts in.
  logic accept;
  logic td_w, et_w, open_w, close_w, instr_w, esc_set_w, strc_w, bt_new_w;
  logic text1, string1, esc1;

  assign accept = in_valid && in_ready;

  always_comb begin
    td_w = in_text_r && !in_string_r && (hist[D-3] == pdfte_pkg::CH_T)
        && (hist[D-2] == pdfte_pkg::CH_D) && pdfte_pkg::is_gap(hist[D-1])
        && pdfte_pkg::is_gap(hist[D-4]);
    et_w = in_text_r && !in_string_r && (hist[D-3] == pdfte_pkg::CH_E)
        && (hist[D-2] == pdfte_pkg::CH_T) && pdfte_pkg::is_gap(hist[D-1])
        && pdfte_pkg::is_gap(hist[D-4]);
    open_w  = in_text_r && !et_w && (in_byte == pdfte_pkg::CH_LPAR)
           && !in_string_r && !esc_r;
    close_w = in_text_r && !et_w && !open_w && (in_byte == pdfte_pkg::CH_RPAR)
           && in_string_r && !esc_r;
    instr_w   = in_text_r && !et_w && !open_w && !close_w && in_string_r;
    esc_set_w = instr_w && (in_byte == pdfte_pkg::CH_BSL) && !esc_r;
    strc_w    = instr_w && !esc_set_w && pdfte_pkg::is_print(in_byte);
    // BT is checked on the window after the shift.
    bt_new_w = (hist[D-2] == pdfte_pkg::CH_B) && (hist[D-1] == pdfte_pkg::CH_T)
            && pdfte_pkg::is_gap(in_byte) && pdfte_pkg::is_gap(hist[D-3]);

    text1   = et_w ? 1'b0 : in_text_r;
    string1 = open_w ? 1'b1 : (close_w ? 1'b0 : in_string_r);
    esc1    = instr_w ? esc_set_w : esc_r;

    if (in_end_of_stream) begin
      in_text_nxt   = 1'b0;
      in_string_nxt = 1'b0;
      esc_nxt       = 1'b0;
    end else begin
      in_text_nxt   = text1 || bt_new_w;
      in_string_nxt = string1;
      esc_nxt       = esc1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_text_r   <= 1'b0;
      in_string_r <= 1'b0;
      esc_r       <= 1'b0;
    end else if (accept) begin
      in_text_r   <= in_text_nxt;
      in_string_r <= in_string_nxt;
      esc_r       <= esc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      c_r    <= in_byte;
      eos_r  <= in_end_of_stream;
      td_r   <= td_w;
      et_r   <= et_w;
      open_r <= open_w;
      strc_r <= strc_w;
    end
  end

  // Result bytes: the TD part first, then the ET, gap or string byte.
  logic [1:0] p1_n, p2_n;
  logic [7:0] p1_b0, p1_b1, p2_b0, p2_b1;
  logic       td_tab, td_crlf, gap_ok, gap_tab, gap_sp;
  logic [2:0] n_sum;
  logic [pdfte_pkg::Q_CNT_W-1:0] res_n;
  logic [7:0] e_byte [pdfte_pkg::Q_DEPTH];
  logic [pdfte_pkg::CNT_W-1:0] cnt_chain [pdfte_pkg::Q_DEPTH];
  pdfte_pkg::entry_t [pdfte_pkg::Q_DEPTH-1:0] push_ent;

  function automatic logic [pdfte_pkg::CNT_W-1:0] sat_inc(
    input logic [pdfte_pkg::CNT_W-1:0] v
  );
    return (&v) ? v : v + 1'b1;
  endfunction

  always_comb begin
    td_tab  = !num_a.any || (num_a.ip == '0);
    td_crlf = !td_tab && ((num_a.ip > pdfte_pkg::IP_W'(1)) || num_a.frac_nz);
    gap_ok  = num_b.any && (num_b.ip != '0);
    gap_tab = gap_ok && (num_b.ip > pdfte_pkg::IP_W'(tab_thr_r));
    gap_sp  = gap_ok && !gap_tab && (num_b.ip > pdfte_pkg::IP_W'(space_thr_r));

    p1_n  = 2'd0;
    p1_b0 = pdfte_pkg::CH_CR;
    p1_b1 = pdfte_pkg::CH_LF;
    if (td_r) begin
      if (td_tab) begin
        p1_n  = 2'd1;
        p1_b0 = pdfte_pkg::CH_TAB;
      end else if (td_crlf) begin
        p1_n = 2'd2;
      end
    end

    p2_n  = 2'd0;
    p2_b0 = pdfte_pkg::CH_CR;
    p2_b1 = pdfte_pkg::CH_LF;
    if (et_r) begin
      p2_n = 2'd2;
    end else if (open_r) begin
      if (gap_tab) begin
        p2_n  = 2'd1;
        p2_b0 = pdfte_pkg::CH_TAB;
      end else if (gap_sp) begin
        p2_n  = 2'd1;
        p2_b0 = pdfte_pkg::CH_SPACE;
      end
    end else if (strc_r) begin
      p2_n  = 2'd1;
      p2_b0 = c_r;
    end

    unique case (p1_n)
      2'd0: begin
        e_byte[0] = p2_b0;
        e_byte[1] = p2_b1;
        e_byte[2] = p2_b1;
      end
      2'd1: begin
        e_byte[0] = p1_b0;
        e_byte[1] = p2_b0;
        e_byte[2] = p2_b1;
      end
      2'd2: begin
        e_byte[0] = p1_b0;
        e_byte[1] = p1_b1;
        e_byte[2] = p2_b0;
      end
      default: begin
        e_byte[0] = p1_b0;
        e_byte[1] = p1_b1;
        e_byte[2] = p2_b0;
      end
    endcase

    n_sum = {1'b0, p1_n} + {1'b0, p2_n};
    res_n = (n_sum > 3'(pdfte_pkg::Q_DEPTH)) ? pdfte_pkg::Q_CNT_W'(pdfte_pkg::Q_DEPTH)
          : n_sum[pdfte_pkg::Q_CNT_W-1:0];

    cnt_chain[0] = sat_inc(counter_r);
    for (int k = 1; k < pdfte_pkg::Q_DEPTH; k++) begin
      cnt_chain[k] = sat_inc(cnt_chain[k - 1]);
    end

    for (int k = 0; k < pdfte_pkg::Q_DEPTH; k++) begin
      push_ent[k].text_byte = e_byte[k];
      push_ent[k].last      = (pdfte_pkg::Q_CNT_W'(k) == res_n - 1'b1);
      push_ent[k].count     = cnt_chain[k];
    end

    if (eos_r) begin
      counter_nxt = '0;
    end else if (res_n == '0) begin
      counter_nxt = counter_r;
    end else begin
      counter_nxt = cnt_chain[res_n - 1'b1];
    end
  end

  // Result queue.
  logic              push, commit, q_empty, work_go;
  pdfte_pkg::entry_t q_head;

  pdfte_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_n   (res_n),
    .push_ent (push_ent),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .head     (q_head),
    .empty    (q_empty)
  );

  assign out_text_byte     = q_head.text_byte;
  assign out_last_of_run   = q_head.last;
  assign out_emitted_count = q_head.count;

  // A byte with results waits until the previous byte's results have all left.
  assign work_go = (res_n == '0) || q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      counter_r <= '0;
    end else if (commit) begin
      counter_r <= counter_nxt;
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pdfte_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = (td_w || open_w) ? pdfte_pkg::ST_SCAN : pdfte_pkg::ST_WORK;
        end
      end
      pdfte_pkg::ST_SCAN: begin
        if (scan_cnt_r == pdfte_pkg::HIST_CNT_W'(D - 1)) begin
          state_nxt = pdfte_pkg::ST_WORK;
        end
      end
      pdfte_pkg::ST_WORK: begin
        if (work_go) begin
          state_nxt = pdfte_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pdfte_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cell_op  = pdfte_pkg::CELL_HOLD;
    rot_sel  = 1'b0;
    scan_ctl = '0;
    push     = 1'b0;
    commit   = 1'b0;
    unique case (state_r)
      pdfte_pkg::ST_IDLE: begin
        in_ready       = 1'b1;
        scan_ctl.start = in_valid;
      end
      pdfte_pkg::ST_SCAN: begin
        // Each rotation brings the next slot into cell 1; a full turn restores the window.
        cell_op       = pdfte_pkg::CELL_LOAD;
        rot_sel       = 1'b1;
        scan_ctl.step = (scan_cnt_r < pdfte_pkg::HIST_CNT_W'(pdfte_pkg::SCAN_STEPS));
        scan_ctl.snap = (scan_cnt_r == pdfte_pkg::HIST_CNT_W'(pdfte_pkg::SNAP_AT));
      end
      pdfte_pkg::ST_WORK: begin
        if (work_go) begin
          commit  = 1'b1;
          push    = (res_n != '0);
          cell_op = eos_r ? pdfte_pkg::CELL_CLEAR : pdfte_pkg::CELL_LOAD;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= pdfte_pkg::ST_IDLE;
      scan_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == pdfte_pkg::ST_SCAN) begin
        scan_cnt_r <= scan_cnt_r + 1'b1;
      end else begin
        scan_cnt_r <= '0;
      end
    end
  end

  `PTE_ASSERT_NEXT(a_accept_leaves_idle, in_valid && in_ready, state_r != pdfte_pkg::ST_IDLE)
  `PTE_ASSERT_IMPL(a_push_into_empty, push, q_empty)
  `PTE_ASSERT_IMPL(a_string_in_text, in_string_r, in_text_r)
  `PTE_ASSERT_IMPL(a_escape_in_string, esc_r, in_string_r)
  `PTE_ASSERT_IMPL(a_count_nonzero, out_valid, out_emitted_count != '0)

endmodule

`default_nettype wire
